### rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// types and constants shared by the modem power sequencer
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int unsigned RegCount  = 6;
    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    // register indexes
    typedef enum logic [2:0] {
        REG_LEVEL_A    = 3'd0,
        REG_LEVEL_B    = 3'd1,
        REG_LEVEL_C    = 3'd2,
        REG_LEVEL_D    = 3'd3,
        REG_UP_WAIT    = 3'd4,
        REG_DOWN_WAIT  = 3'd5
    } reg_index_t;

    localparam logic [7:0] LevelAReset  = 8'd10;
    localparam logic [7:0] LevelBReset  = 8'd25;
    localparam logic [7:0] LevelCReset  = 8'd49;
    localparam logic [7:0] LevelDReset  = 8'd74;
    localparam logic [7:0] UpWaitReset   = 8'd20;
    localparam logic [7:0] DownWaitReset = 8'd2;

    // power event codes
    localparam logic [1:0] PEV_NONE  = 2'd0;
    localparam logic [1:0] PEV_DOWN  = 2'd1;
    localparam logic [1:0] PEV_ABORT = 2'd2;

    // activation command codes
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_ACTIVE   = 2'd1;
    localparam logic [1:0] CMD_INACTIVE = 2'd2;

    // reported sequence codes
    localparam logic [2:0] RPT_IDLE      = 3'd0;
    localparam logic [2:0] RPT_WAIT_PWR  = 3'd1;
    localparam logic [2:0] RPT_WAIT_ACT  = 3'd2;
    localparam logic [2:0] RPT_ACTIVE    = 3'd3;
    localparam logic [2:0] RPT_DACT      = 3'd4;
    localparam logic [2:0] RPT_WAIT_DACT = 3'd5;

    typedef enum logic [5:0] {
        SEQ_IDLE      = 6'b000001,
        SEQ_WAIT_PWR  = 6'b000010,
        SEQ_WAIT_ACT  = 6'b000100,
        SEQ_ACTIVE    = 6'b001000,
        SEQ_DACT      = 6'b010000,
        SEQ_WAIT_DACT = 6'b100000
    } seq_state_t;

    typedef struct packed {
        logic       off_request_pin;
        logic       modem_switch;
        logic       link_connected;
        logic       link_idle;
        logic [7:0] signal_level;
        logic       halt_request;
    } item_t;

    typedef struct packed {
        logic       heartbeat;
        logic       modem_power;
        logic       link_led;
        logic [3:0] level_bar;
        logic [1:0] power_event;
        logic [1:0] activate_command;
        logic       idle_timeout_warning;
        logic [2:0] sequence_state;
    } result_t;

    function automatic logic [2:0] seq_code(input seq_state_t s);
        logic [2:0] code;
        code = RPT_IDLE;
        unique case (s)
            SEQ_IDLE:      code = RPT_IDLE;
            SEQ_WAIT_PWR:  code = RPT_WAIT_PWR;
            SEQ_WAIT_ACT:  code = RPT_WAIT_ACT;
            SEQ_ACTIVE:    code = RPT_ACTIVE;
            SEQ_DACT:      code = RPT_DACT;
            SEQ_WAIT_DACT: code = RPT_WAIT_DACT;
            default:       code = RPT_IDLE;
        endcase
        return code;
    endfunction

endpackage

### rtl/modem_power_sequencer.sv
// The sequencer takes one tick item per clock cycle while item_ready is high and returns
// exactly one result item per tick. A tick's result is computed in the cycle it is accepted
// and held from the next cycle on in the output register, or in a second result register
// behind it while the first result waits, so item_ready only drops when both are full.
// Thresholds and wait lengths are written over the APB port at byte addresses 0x00 to 0x14;
// the user must write them only while no tick is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
// modem_power_sequencer
// modem power/activation sequencing, power-off pin tracking and signal-level bar
// ----------------------------------------------------------------------------
module modem_power_sequencer
    import mps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,

    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready
);

    // configuration registers
    logic [7:0] level_a_reg, level_b_reg, level_c_reg, level_d_reg;
    logic [7:0] up_wait_reg, down_wait_reg;

    // sequencer state
    seq_state_t seq_state_reg, seq_state_next;
    logic       last_switch_reg, last_switch_next;
    logic       started_reg, started_next;
    logic       pending_reg, pending_next;
    logic       halted_reg, halted_next;
    logic       blink_reg, blink_next;
    logic       led_reg, led_next;
    logic       power_reg, power_next;
    logic [7:0] elapsed_reg, elapsed_next;
    logic [3:0] bar_reg, bar_next;

    // output buffer
    logic    out_valid_reg, skid_valid_reg;
    result_t out_item_reg, skid_item_reg;
    result_t res_next;

    logic       item_accept, result_accept, cfg_write;
    reg_index_t cfg_index;
    logic [1:0] pev, cmd;
    logic       warn;
    logic       apply_switch;

    assign item_accept   = item_valid && item_ready;
    assign result_accept = result_valid && result_ready;
    assign item_ready    = !skid_valid_reg;
    assign result_valid  = out_valid_reg;
    assign result        = out_item_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[AddrWidth-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_LEVEL_A:   prdata = {24'd0, level_a_reg};
            REG_LEVEL_B:   prdata = {24'd0, level_b_reg};
            REG_LEVEL_C:   prdata = {24'd0, level_c_reg};
            REG_LEVEL_D:   prdata = {24'd0, level_d_reg};
            REG_UP_WAIT:   prdata = {24'd0, up_wait_reg};
            REG_DOWN_WAIT: prdata = {24'd0, down_wait_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_a_reg   <= LevelAReset;
            level_b_reg   <= LevelBReset;
            level_c_reg   <= LevelCReset;
            level_d_reg   <= LevelDReset;
            up_wait_reg   <= UpWaitReset;
            down_wait_reg <= DownWaitReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LEVEL_A:   level_a_reg   <= pwdata[7:0];
                REG_LEVEL_B:   level_b_reg   <= pwdata[7:0];
                REG_LEVEL_C:   level_c_reg   <= pwdata[7:0];
                REG_LEVEL_D:   level_d_reg   <= pwdata[7:0];
                REG_UP_WAIT:   up_wait_reg   <= pwdata[7:0];
                REG_DOWN_WAIT: down_wait_reg <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // ---------------- tick logic ----------------
    always_comb
    begin
        seq_state_next   = seq_state_reg;
        last_switch_next = last_switch_reg;
        started_next     = started_reg;
        pending_next     = pending_reg;
        halted_next      = halted_reg | item.halt_request;
        blink_next       = blink_reg;
        led_next         = led_reg;
        power_next       = power_reg;
        elapsed_next     = elapsed_reg;
        bar_next         = bar_reg;
        pev              = PEV_NONE;
        cmd              = CMD_NONE;
        warn             = 1'b0;
        apply_switch     = !started_reg || (item.modem_switch != last_switch_reg);

        if (!halted_next)
        begin
            if (elapsed_reg != 8'hff)
                elapsed_next = elapsed_reg + 8'd1;

            if (item.off_request_pin)
            begin
                pending_next = 1'b1;
                pev          = PEV_DOWN;
            end
            else if (pending_reg)
            begin
                pending_next = 1'b0;
                pev          = PEV_ABORT;
            end

            // first tick applies the switch whatever its level
            if (apply_switch)
            begin
                started_next     = 1'b1;
                last_switch_next = item.modem_switch;
                if (item.modem_switch)
                begin
                    power_next     = 1'b1;
                    seq_state_next = SEQ_WAIT_PWR;
                    elapsed_next   = 8'd0;
                end
                else
                begin
                    seq_state_next = SEQ_DACT;
                end
            end

            unique case (seq_state_next)
                SEQ_WAIT_PWR:
                begin
                    if (elapsed_next >= up_wait_reg)
                    begin
                        cmd            = CMD_ACTIVE;
                        seq_state_next = SEQ_WAIT_ACT;
                    end
                    else
                    begin
                        blink_next = !blink_reg;
                        led_next   = !blink_reg;
                    end
                end
                SEQ_WAIT_ACT:
                begin
                    if (item.link_connected)
                    begin
                        led_next       = 1'b1;
                        blink_next     = 1'b1;
                        seq_state_next = SEQ_ACTIVE;
                    end
                    else
                    begin
                        blink_next = !blink_reg;
                        led_next   = !blink_reg;
                    end
                end
                SEQ_DACT:
                begin
                    cmd            = CMD_INACTIVE;
                    led_next       = 1'b1;
                    elapsed_next   = 8'd0;
                    seq_state_next = SEQ_WAIT_DACT;
                end
                SEQ_WAIT_DACT:
                begin
                    if (elapsed_next >= down_wait_reg)
                    begin
                        warn           = !item.link_idle;
                        power_next     = 1'b0;
                        led_next       = 1'b0;
                        blink_next     = 1'b0;
                        seq_state_next = SEQ_IDLE;
                    end
                end
                default: ;
            endcase

            bar_next = {item.signal_level > level_a_reg,
                        item.signal_level > level_b_reg,
                        item.signal_level > level_c_reg,
                        item.signal_level > level_d_reg};
        end

        res_next.heartbeat            = !halted_next;
        res_next.modem_power          = power_next;
        res_next.link_led             = led_next;
        res_next.level_bar            = bar_next;
        res_next.power_event          = pev;
        res_next.activate_command     = cmd;
        res_next.idle_timeout_warning = warn;
        res_next.sequence_state       = seq_code(seq_state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg   <= SEQ_IDLE;
            last_switch_reg <= 1'b0;
            started_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            halted_reg      <= 1'b0;
            blink_reg       <= 1'b1;
            led_reg         <= 1'b1;
            power_reg       <= 1'b0;
            elapsed_reg     <= 8'd0;
            bar_reg         <= 4'hf;
        end
        else if (item_accept)
        begin
            seq_state_reg   <= seq_state_next;
            last_switch_reg <= last_switch_next;
            started_reg     <= started_next;
            pending_reg     <= pending_next;
            halted_reg      <= halted_next;
            blink_reg       <= blink_next;
            led_reg         <= led_next;
            power_reg       <= power_next;
            elapsed_reg     <= elapsed_next;
            bar_reg         <= bar_next;
        end
    end

    // ---------------- result buffer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || result_accept)
            begin
                // output slot frees up: older skid item goes first
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= item_accept;
                end
            end
            else if (item_accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result_accept)
        begin
            if (skid_valid_reg)
                out_item_reg <= skid_item_reg;
            else if (item_accept)
                out_item_reg <= res_next;
        end
        if (item_accept && out_valid_reg && !result_accept)
            skid_item_reg <= res_next;
    end

    // ---------------- assertions ----------------
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while output register is empty");

    a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && halted_reg) |=>
            ($stable(seq_state_reg) && $stable(power_reg) && $stable(elapsed_reg)))
        else $error("state moved after halt");

    a_halt_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (halted_reg || item.halt_request)) |->
            (!res_next.heartbeat && res_next.power_event == PEV_NONE
             && res_next.activate_command == CMD_NONE))
        else $error("halted tick emitted an event");

endmodule
